// File: rtl/mdsc_pkg.sv
// Shared types, constants and helpers for the mix-to-DMA sample converter.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package mdsc_pkg;

  // Ring address space and the cap on the programmed ring size.
  localparam int unsigned RING_ADDR_BITS = 16;
  localparam int unsigned ADDR_W         = 16;
  localparam int unsigned RING_CAP_BITS  = (RING_ADDR_BITS < ADDR_W) ? RING_ADDR_BITS : ADDR_W;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned LOG2_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [SAMP_W-1:0] SAT_MAX = 16'h7fff;   // +32767
  localparam logic [SAMP_W-1:0] SAT_MIN = 16'h8000;   // -32768

  localparam logic [LOG2_W-1:0] RING_LOG2_RST = 5'd16;
  localparam logic [LOG2_W-1:0] RING_CAP      = LOG2_W'(RING_CAP_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2 = 2'd2;

  typedef logic signed [ACC_W-1:0] accum_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [SAMP_W-1:0]       sample_t;

  // Floor shift by the fraction width, then saturate to signed 16 bits.
  function automatic sample_t clip_s16(input accum_t acc);
    logic [ACC_W-FRAC_W-1:0] v;
    logic                    hi_ones;
    logic                    hi_zeros;
    v        = acc[ACC_W-1:FRAC_W];
    hi_ones  = &v[ACC_W-FRAC_W-1:SAMP_W-1];
    hi_zeros = ~|v[ACC_W-FRAC_W-1:SAMP_W-1];
    if (!v[ACC_W-FRAC_W-1] && !hi_zeros) begin
      return SAT_MAX;
    end else if (v[ACC_W-FRAC_W-1] && !hi_ones) begin
      return SAT_MIN;
    end
    return v[SAMP_W-1:0];
  endfunction

  // 16-bit two's complement, or offset binary byte (high byte plus 128).
  function automatic sample_t format_sample(input sample_t s, input logic eight_bit);
    if (eight_bit) begin
      return {8'h00, ~s[SAMP_W-1], s[SAMP_W-2:SAMP_W-8]};
    end
    return s;
  endfunction

  // Wrap mask from the programmed ring size, capped to the address space.
  function automatic addr_t ring_mask(input logic [LOG2_W-1:0] log2_n);
    logic [LOG2_W-1:0] n;
    addr_t             m;
    n = (log2_n > RING_CAP) ? RING_CAP : log2_n;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (LOG2_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// File: rtl/mdsc_in_if.sv
// Input channel: one stereo pair of mix accumulators per transfer.
// Depends on mdsc_pkg.
`timescale 1ns / 1ps

interface mdsc_in_if;
  logic              valid;
  logic              ready;
  mdsc_pkg::accum_t  left_accum;
  mdsc_pkg::accum_t  right_accum;
  logic              end_of_block;

  modport source (output valid, left_accum, right_accum, end_of_block, input ready);
  modport sink   (input valid, left_accum, right_accum, end_of_block, output ready);
endinterface

// File: rtl/mdsc_out_if.sv
// Result channel: one ring write (address and sample) per transfer.
// Depends on mdsc_pkg.
`timescale 1ns / 1ps

interface mdsc_out_if;
  logic              valid;
  logic              ready;
  mdsc_pkg::addr_t   ring_address;
  mdsc_pkg::sample_t sample_word;
  logic              last_of_item;
  logic              block_done;

  modport source (output valid, ring_address, sample_word, last_of_item, block_done,
                  input ready);
  modport sink   (input valid, ring_address, sample_word, last_of_item, block_done,
                  output ready);
endinterface

// File: rtl/mix_to_dma_sample_converter_unit.sv
// Mix-to-DMA sample converter: clip 24.8 accumulators to 16 bits and write the ring.
// An accepted pair passes through the pair register, then the output register.
// Throughput: one write per cycle while out_ch is ready; a stereo pair gives two writes,
// mono one; a free pair register takes the next pair while a result waits on out_ch.
// Reset (rst_n low, synchronous): both stages empty, write index 0, 16-bit stereo,
// ring size log2 = 16. Depends on mdsc_pkg, mdsc_in_if, mdsc_out_if.
`timescale 1ns / 1ps

module mix_to_dma_sample_converter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  mdsc_in_if.sink                             in_ch,
  mdsc_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [mdsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mdsc_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic              eight_bit_r;
  logic              mono_r;
  logic [LOG2_W-1:0] ring_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_bit_r <= 1'b0;
      mono_r      <= 1'b0;
      ring_log2_r <= RING_LOG2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EIGHT_BIT: eight_bit_r <= cfg_wdata[0];
        CFG_MONO:      mono_r      <= cfg_wdata[0];
        CFG_RING_LOG2: ring_log2_r <= cfg_wdata[LOG2_W-1:0];
        default: ;     // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pair register: holds the accepted stereo pair until both halves
  // (or just the left in mono) have gone to the output register.
  // ---------------------------------------------------------------
  logic   pair_vld_r;
  logic   left_done_r;     // left half already handed on
  accum_t left_r;
  accum_t right_r;
  logic   eob_r;

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic    out_vld_r;
  addr_t   out_addr_r;
  sample_t out_samp_r;
  logic    out_last_r;
  logic    out_done_r;

  addr_t   write_index_r;
  addr_t   write_index_nxt;
  addr_t   mask;

  logic    out_load;       // output register takes a new result this cycle
  logic    emit_last;      // that result closes the current pair
  logic    in_xfer;
  accum_t  sel_acc;
  sample_t sel_samp;

  assign out_load  = pair_vld_r && (!out_vld_r || out_ch.ready);
  assign emit_last = mono_r || left_done_r;

  // Pair register frees up when its last half leaves; take the next pair then.
  assign in_ch.ready = !pair_vld_r || (out_load && emit_last);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign sel_acc  = left_done_r ? right_r : left_r;
  assign sel_samp = format_sample(clip_s16(sel_acc), eight_bit_r);

  // New mask applies straight away, to the current index.
  assign mask            = ring_mask(ring_log2_r);
  assign write_index_nxt = (write_index_r + 16'd1) & mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r  <= 1'b0;
      left_done_r <= 1'b0;
    end else if (in_xfer) begin
      pair_vld_r  <= 1'b1;
      left_done_r <= 1'b0;
    end else if (out_load) begin
      pair_vld_r  <= !emit_last;
      left_done_r <= !emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_r  <= in_ch.left_accum;
      right_r <= in_ch.right_accum;
      eob_r   <= in_ch.end_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r     <= 1'b0;
      write_index_r <= '0;
    end else if (out_load) begin
      out_vld_r     <= 1'b1;
      write_index_r <= write_index_nxt;
    end else if (out_ch.ready) begin
      out_vld_r     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= write_index_r & mask;
      out_samp_r <= sel_samp;
      out_last_r <= emit_last;
      out_done_r <= emit_last && eob_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.ring_address = out_addr_r;
  assign out_ch.sample_word  = out_samp_r;
  assign out_ch.last_of_item = out_last_r;
  assign out_ch.block_done   = out_done_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_left_done_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
    left_done_r |-> pair_vld_r)
    else $error("left-half flag set with no pair held");

  a_accept_fresh_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> pair_vld_r && !left_done_r)
    else $error("accepted pair not held with left half pending");

  a_left_then_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_last_r |-> pair_vld_r && left_done_r)
    else $error("left sample out but right half not pending");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_done_r |-> out_last_r)
    else $error("block_done on a result that is not last of its pair");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(write_index_r))
    else $error("write index moved without a ring write");

endmodule
